FILE: design/rbsi_pkg.sv
// shared widths, defaults and types for the ray box slab intersection block
package rbsi_pkg;

    // coordinate and distance width, fixed by the item format
    localparam int COORD_W       = 32;
    // default fraction bits of the fixed point format
    localparam int FRAC_BITS_DEF = 16;
    // number of axes and input fields per item
    localparam int NUM_AXES      = 3;
    localparam int IN_FIELDS     = 4 * NUM_AXES;
    // stream data widths, padded to whole bytes
    localparam int S_DATA_W      = IN_FIELDS * COORD_W;
    localparam int M_DATA_W      = 8;
    // register stages from the slab inputs to the registered distances
    localparam int SLAB_STAGES   = 3;

    // entry and exit distance of one axis
    typedef struct packed {
        logic signed [COORD_W-1:0] t_near;
        logic signed [COORD_W-1:0] t_far;
    } slab_t;

endpackage

FILE: design/rbsi_slab.sv
// one axis of the slab test: plane select, subtract, multiply, floor and saturate
module rbsi_slab #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [rbsi_pkg::COORD_W-1:0]  origin,
    input  logic signed [rbsi_pkg::COORD_W-1:0]  inv_dir,
    input  logic signed [rbsi_pkg::COORD_W-1:0]  box_min,
    input  logic signed [rbsi_pkg::COORD_W-1:0]  box_max,
    output rbsi_pkg::slab_t                      dist_out
);
    import rbsi_pkg::*;

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + COORD_W;

    logic signed [COORD_W-1:0] near_pl;
    logic signed [COORD_W-1:0] far_pl;
    logic signed [DIFF_W-1:0]  dn_next, df_next, dn_reg, df_reg;
    logic signed [COORD_W-1:0] inv_reg;
    logic signed [PROD_W-1:0]  pn_next, pf_next, pn_reg, pf_reg;
    slab_t                     dist_next, dist_reg;

    // floor to the coordinate format, then clamp to 32 bits
    function automatic logic signed [COORD_W-1:0] floor_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] sh;
        logic                     fits;
        sh   = p >>> FRAC_BITS;
        fits = (&sh[PROD_W-1:COORD_W-1]) || !(|sh[PROD_W-1:COORD_W-1]);
        if (fits) begin
            floor_sat = sh[COORD_W-1:0];
        end else if (sh[PROD_W-1]) begin
            floor_sat = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            floor_sat = {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    // stage 1: negative reciprocal makes the upper corner near
    always_comb begin
        near_pl = inv_dir[COORD_W-1] ? box_max : box_min;
        far_pl  = inv_dir[COORD_W-1] ? box_min : box_max;
        dn_next = {near_pl[COORD_W-1], near_pl} - {origin[COORD_W-1], origin};
        df_next = {far_pl[COORD_W-1], far_pl} - {origin[COORD_W-1], origin};
    end

    // stage 2: exact products
    always_comb begin
        pn_next = PROD_W'(dn_reg) * PROD_W'(inv_reg);
        pf_next = PROD_W'(df_reg) * PROD_W'(inv_reg);
    end

    // stage 3: back to the coordinate format
    always_comb begin
        dist_next.t_near = floor_sat(pn_reg);
        dist_next.t_far  = floor_sat(pf_reg);
    end

    // pipeline registers, held while the block is stalled
    always_ff @(posedge aclk) begin
        if (en) begin
            dn_reg   <= dn_next;
            df_reg   <= df_next;
            inv_reg  <= inv_dir;
            pn_reg   <= pn_next;
            pf_reg   <= pf_next;
            dist_reg <= dist_next;
        end
    end

    assign dist_out = dist_reg;

endmodule

FILE: design/ray_box_slab_intersect_top.sv
// top level of the ray versus axis-aligned box slab test
// Usage:
// The s_ channel takes one test per item: ray origin, per-axis reciprocal of
// the direction and the box corners, all signed fixed point with FRAC_BITS
// fraction bits in 32-bit fields. A zero direction component is given as a
// saturated reciprocal. The m_ channel returns one item per test, with the
// hit flag in bit 0 of m_tdata.
// An accepted item passes through registered stages to m_tvalid: plane select and
// subtract, multiply, floor and saturate, x/y interval merge, z merge and
// hit decision. One item is taken every cycle while the result side drains.
// The multiply stage, six 33x32 products in parallel, sets the clock.
// Reset clears every valid bit; the pipe comes up empty and ready.
// When the receiver stalls with a result waiting, the whole pipe holds and
// s_tready drops; no item is lost or repeated, and results leave in order.
module ray_box_slab_intersect_top #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [rbsi_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // hit, then zero padding
    output logic [rbsi_pkg::M_DATA_W-1:0]   m_tdata
);
    import rbsi_pkg::*;

    logic                      en;
    logic [SLAB_STAGES-1:0]    vld_reg, vld_next;
    slab_t                     axis_dist [NUM_AXES];

    logic                      v4_reg, v4_next;
    logic                      ok4_reg, ok4_next;
    logic signed [COORD_W-1:0] tmin4_reg, tmin4_next, tmax4_reg, tmax4_next;
    slab_t                     z4_reg;

    logic                      out_vld_reg, out_vld_next;
    logic                      hit_reg, hit_next;

    // global advance: output register free or being taken
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // one slab unit per axis
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        rbsi_slab #(
            .FRAC_BITS (FRAC_BITS)
        ) u_slab (
            .aclk     (aclk),
            .en       (en),
            .origin   (s_tdata[a*COORD_W +: COORD_W]),
            .inv_dir  (s_tdata[(NUM_AXES+a)*COORD_W +: COORD_W]),
            .box_min  (s_tdata[(2*NUM_AXES+a)*COORD_W +: COORD_W]),
            .box_max  (s_tdata[(3*NUM_AXES+a)*COORD_W +: COORD_W]),
            .dist_out (axis_dist[a])
        );
    end

    // valid bits running beside the slab units
    assign vld_next = {vld_reg[SLAB_STAGES-2:0], s_tvalid};

    // stage 4: overlap of x and y, narrowed interval
    always_comb begin
        v4_next    = vld_reg[SLAB_STAGES-1];
        ok4_next   = !((axis_dist[0].t_near > axis_dist[1].t_far) ||
                       (axis_dist[1].t_near > axis_dist[0].t_far));
        tmin4_next = (axis_dist[1].t_near > axis_dist[0].t_near) ?
                     axis_dist[1].t_near : axis_dist[0].t_near;
        tmax4_next = (axis_dist[1].t_far < axis_dist[0].t_far) ?
                     axis_dist[1].t_far : axis_dist[0].t_far;
    end

    // stage 5: overlap with z and the non-negative distance check
    always_comb begin
        logic overlap;
        logic near_neg;
        logic far_neg;
        overlap      = !((tmin4_reg > z4_reg.t_far) || (z4_reg.t_near > tmax4_reg));
        near_neg     = tmin4_reg[COORD_W-1] && z4_reg.t_near[COORD_W-1];
        far_neg      = tmax4_reg[COORD_W-1] || z4_reg.t_far[COORD_W-1];
        hit_next     = ok4_reg && overlap && !(near_neg && far_neg);
        out_vld_next = v4_reg;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            v4_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= vld_next;
            v4_reg      <= v4_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            ok4_reg   <= ok4_next;
            tmin4_reg <= tmin4_next;
            tmax4_reg <= tmax4_next;
            z4_reg    <= axis_dist[2];
            hit_reg   <= hit_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_DATA_W-1){1'b0}}, hit_reg};

endmodule
